// File: sv/cpd_pkg.sv
// Shared types, constants and fixed-point helpers for the conic point distance block.
// No dependencies; every other file but cpd_delay imports this package.
`default_nettype none

package cpd_pkg;

  localparam int COEF_W     = 32;
  localparam int TOL_W      = 31;
  localparam int DIST_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd6;

  // Saturation bound of the double-width intermediates
  localparam logic signed [63:0] WLIM = 64'sh4000_0000_0000_0000;
  localparam logic [DIST_W-1:0]  DMAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CLS_ELLIPSE   = 3'd0,
    CLS_HYPERBOLA = 3'd1,
    CLS_PARABOLA  = 3'd2,
    CLS_TWO_LINES = 3'd3,
    CLS_LINE      = 3'd4,
    CLS_NONE      = 3'd5
  } conic_class_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_const;
    logic signed [COEF_W-1:0] coef_x;
    logic signed [COEF_W-1:0] coef_y;
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] coef_yy;
    logic        [TOL_W-1:0]  tolerance;
  } cpd_cfg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] conic_value;
    logic signed [COEF_W-1:0] grad_x;
    logic signed [COEF_W-1:0] grad_y;
    logic        [DIST_W-1:0] approx_distance;
    logic                     distance_invalid;
    conic_class_t             conic_class;
  } cpd_res_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Add two values within +-WLIM and clamp the sum to +-WLIM
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(WLIM)) return WLIM;
    else if (s < -65'(WLIM)) return -WLIM;
    else return s[63:0];
  endfunction

  // Shift right, rounding half away from zero; |v| <= WLIM
  function automatic logic signed [63:0] rshr64(input logic signed [63:0] v, input int sh);
    logic [63:0] u;
    u = (mag64(v) + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? 64'(-u) : 64'(u);
  endfunction

  // Round to the single-width format and saturate to 32 bits
  function automatic logic signed [31:0] rnd_sat32(input logic signed [63:0] v, input int sh);
    logic [63:0] u;
    logic signed [31:0] r;
    u = (mag64(v) + (64'd1 << (sh - 1))) >> sh;
    if (!v[63]) r = (u > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : u[31:0];
    else r = (u > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-u[31:0]);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/cpd_if.sv
// Stream channels of the conic point distance block: points in, results out.
// Depends on cpd_pkg.
`default_nettype none

interface cpd_in_if;
  import cpd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] point_x;
  logic signed [COEF_W-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface cpd_out_if;
  import cpd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] conic_value;
  logic signed [COEF_W-1:0] grad_x;
  logic signed [COEF_W-1:0] grad_y;
  logic        [DIST_W-1:0] approx_distance;
  logic                     distance_invalid;
  conic_class_t             conic_class;

  modport source (output valid, conic_value, grad_x, grad_y, approx_distance,
                  distance_invalid, conic_class, input ready);
  modport sink   (input valid, conic_value, grad_x, grad_y, approx_distance,
                  distance_invalid, conic_class, output ready);
endinterface

`default_nettype wire

// File: sv/cpd_mulsh.sv
// Two-stage product of a double-width and a single-width value, shifted down,
// rounded half away from zero and clamped to +-WLIM. Depends on cpd_pkg.
`default_nettype none

module cpd_mulsh #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);
  import cpd_pkg::*;

  logic [63:0] ma;
  logic [31:0] mb;
  logic [63:0] pl;
  logic [63:0] ph;
  logic        neg;
  logic [96:0] sum;
  logic [96:0] shv;
  logic [63:0] r;

  assign ma = mag64(a);
  assign mb = mag32(b);

  // Partial products on the two halves of a
  always_ff @(posedge clk) begin
    if (en) begin
      pl  <= ma[31:0] * mb;
      ph  <= ma[63:32] * mb;
      neg <= a[63] ^ b[31];
    end
  end

  always_comb begin
    sum = {1'b0, ph, 32'd0} + 97'(pl) + (97'd1 << (FRAC_BITS - 1));
    shv = sum >> FRAC_BITS;
    r   = (shv > 97'(WLIM)) ? 64'(WLIM) : shv[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg ? 64'(-r) : r;
    end
  end

endmodule

`default_nettype wire

// File: sv/cpd_sqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on cpd_pkg.
`default_nettype none

module cpd_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import cpd_pkg::*;

  logic [63:0] rq [0:SQRT_STEPS-1];
  logic [63:0] vq [0:SQRT_STEPS-2];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] v_in;
    logic [63:0] r_in;
    logic [63:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in = rad;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = vq[k-1];
      assign r_in = rq[k-1];
    end

    assign trial = r_in + BIT;
    assign ge    = v_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rq[k] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
      end
    end

    if (k < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          vq[k] <= ge ? v_in - trial : v_in;
        end
      end
    end
  end

  assign root = rq[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

// File: sv/cpd_div.sv
// Pipelined restoring divider: 31-bit floored quotient and an overflow flag
// for quotients that do not fit. Depends on cpd_pkg.
`default_nettype none

module cpd_div #(
  parameter int NUM_W = 49
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [NUM_W-1:0]        num,
  input  logic [32:0]             den,
  output logic [cpd_pkg::DIST_W-1:0] quo,
  output logic                    ovf
);
  import cpd_pkg::*;

  logic [32:0]       rr [0:DIV_STEPS-1];
  logic [30:0]       lo [0:DIV_STEPS-1];
  logic [32:0]       dd [0:DIV_STEPS-1];
  logic [DIST_W-1:0] qq [0:DIV_STEPS];
  logic              ov [0:DIV_STEPS];
  logic [NUM_W-32:0] r0;

  assign r0 = num[NUM_W-1:31];

  // Quotient overflows when the high part already reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rr[0] <= 33'(r0);
      lo[0] <= num[30:0];
      dd[0] <= den;
      qq[0] <= '0;
      ov[0] <= 34'(r0) >= 34'(den);
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [33:0] trial;
    logic        ge;

    assign trial = {rr[k-1], lo[k-1][DIV_STEPS-k]};
    assign ge    = trial >= {1'b0, dd[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        qq[k] <= {qq[k-1][DIST_W-2:0], ge};
        ov[k] <= ov[k-1];
      end
    end

    if (k < DIV_STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rr[k] <= ge ? 33'(trial - {1'b0, dd[k-1]}) : trial[32:0];
          lo[k] <= lo[k-1];
          dd[k] <= dd[k-1];
        end
      end
    end
  end

  assign quo = qq[DIV_STEPS];
  assign ovf = ov[DIV_STEPS];

endmodule

`default_nettype wire

// File: sv/cpd_delay.sv
// Delay line with valid bits that moves side data in step with a pipelined unit.
// Depends on nothing.
`default_nettype none

module cpd_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic         vq [0:DEPTH-1];
  logic [W-1:0] dq [0:DEPTH-1];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (en) begin
        vq[k] <= (k == 0) ? in_valid : vq[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dq[k] <= (k == 0) ? in_data : dq[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = vq[DEPTH-1];
  assign out_data  = dq[DEPTH-1];

endmodule

`default_nettype wire

// File: sv/cpd_front.sv
// Front pipeline: conic value and gradient at the point, rounded to the single-width
// format, plus |f| and |g|^2 for the distance. Depends on cpd_pkg, cpd_mulsh.
`default_nettype none

module cpd_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  cpd_pkg::cpd_cfg_t     cfg,
  input  logic                  in_valid,
  input  logic signed [31:0]    x,
  input  logic signed [31:0]    y,
  output logic                  out_valid,
  output logic signed [31:0]    f,
  output logic signed [31:0]    gx,
  output logic signed [31:0]    gy,
  output logic [31:0]           fm,
  output logic [63:0]           g2
);
  import cpd_pkg::*;

  localparam int STAGES = 8;

  logic [STAGES-1:0] vld;

  // stage 1
  logic signed [63:0] pxx1, pxyx1, pyy1, px1, py1, pxyy1;
  logic signed [31:0] x1, y1;
  // stage 2
  logic signed [63:0] fa2, gxa2, gya2, py2, pxx2, pyy2, pxyy2, pxyx2;
  // stage 3
  logic signed [63:0] fb3, gxb3, gyb3, pxyy3, pxyx3;
  logic signed [63:0] t3, t4, t5;
  // stage 4
  logic signed [63:0] fc4, gxc4, gyc4, t4_4, t5_4;
  // stage 5
  logic signed [63:0] fd5, t5_5;
  logic signed [31:0] gx5, gy5;
  // stage 6
  logic signed [63:0] fe6;
  logic [63:0]        gxx6, gyy6;
  logic signed [31:0] gx6, gy6;
  // stage 7
  logic signed [31:0] f7, gx7, gy7;
  logic [63:0]        g2_7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // Quadratic terms: (c * u) * v, shifted down
  cpd_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mxx (.clk, .en, .a(pxx1),  .b(x1), .p(t3));
  cpd_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mxy (.clk, .en, .a(pxyx1), .b(y1), .p(t4));
  cpd_mulsh #(.FRAC_BITS(FRAC_BITS)) u_myy (.clk, .en, .a(pyy1),  .b(y1), .p(t5));

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: single products
      pxx1  <= cfg.coef_xx * x;
      pxyx1 <= cfg.coef_xy * x;
      pyy1  <= cfg.coef_yy * y;
      px1   <= cfg.coef_x * x;
      py1   <= cfg.coef_y * y;
      pxyy1 <= cfg.coef_xy * y;
      x1    <= x;
      y1    <= y;
      // stage 2: first saturating sums
      fa2   <= sadd(64'(cfg.coef_const) <<< FRAC_BITS, px1);
      gxa2  <= sadd(64'(cfg.coef_x) <<< FRAC_BITS, pxx1);
      gya2  <= sadd(64'(cfg.coef_y) <<< FRAC_BITS, pyy1);
      py2   <= py1;
      pxx2  <= pxx1;
      pyy2  <= pyy1;
      pxyy2 <= pxyy1;
      pxyx2 <= pxyx1;
      // stage 3
      fb3   <= sadd(fa2, py2);
      gxb3  <= sadd(gxa2, pxx2);
      gyb3  <= sadd(gya2, pyy2);
      pxyy3 <= pxyy2;
      pxyx3 <= pxyx2;
      // stage 4: quadratic terms arrive
      fc4   <= sadd(fb3, t3);
      gxc4  <= sadd(gxb3, pxyy3);
      gyc4  <= sadd(gyb3, pxyx3);
      t4_4  <= t4;
      t5_4  <= t5;
      // stage 5
      fd5   <= sadd(fc4, t4_4);
      t5_5  <= t5_4;
      gx5   <= rnd_sat32(gxc4, FRAC_BITS);
      gy5   <= rnd_sat32(gyc4, FRAC_BITS);
      // stage 6
      fe6   <= sadd(fd5, t5_5);
      gxx6  <= mag32(gx5) * mag32(gx5);
      gyy6  <= mag32(gy5) * mag32(gy5);
      gx6   <= gx5;
      gy6   <= gy5;
      // stage 7
      f7    <= rnd_sat32(fe6, FRAC_BITS);
      g2_7  <= gxx6 + gyy6;
      gx7   <= gx6;
      gy7   <= gy6;
      // stage 8
      f     <= f7;
      fm    <= mag32(f7);
      gx    <= gx7;
      gy    <= gy7;
      g2    <= g2_7;
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule

`default_nettype wire

// File: sv/cpd_conf.sv
// Free-running pipeline on the configuration: quadratic norm q and conic class.
// Depends on cpd_pkg, cpd_mulsh, cpd_sqrt.
`default_nettype none

module cpd_conf #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  cpd_pkg::cpd_cfg_t     cfg,
  output logic [31:0]           q,
  output cpd_pkg::conic_class_t cls
);
  import cpd_pkg::*;

  logic signed [63:0] p12, p11, p22, p35;
  logic [63:0]        m33, m44, m55;
  logic signed [63:0] det;
  logic [63:0]        q2, ps;
  logic signed [63:0] t1, t2, t3, td;
  logic signed [63:0] sa, s, beta;
  logic [63:0]        tol2;
  logic [33:0]        qs;
  logic               det_small;

  always_ff @(posedge clk) begin
    p12 <= cfg.coef_x * cfg.coef_y;
    p11 <= cfg.coef_x * cfg.coef_x;
    p22 <= cfg.coef_y * cfg.coef_y;
    p35 <= cfg.coef_xx * cfg.coef_yy;
    m33 <= mag32(cfg.coef_xx) * mag32(cfg.coef_xx);
    m44 <= mag32(cfg.coef_xy) * mag32(cfg.coef_xy);
    m55 <= mag32(cfg.coef_yy) * mag32(cfg.coef_yy);
    det <= p35 - signed'(m44 >> 2);
    q2  <= m33 + (m44 >> 1) + m55;
    ps  <= 64'(p11) + 64'(p22);
    sa   <= sadd(t1, -t2);
    s    <= sadd(sa, -t3);
    beta <= sadd(td, rshr64(s, 2));
  end

  cpd_mulsh #(.FRAC_BITS(FRAC_BITS)) u_t1 (.clk, .en(1'b1), .a(p12), .b(cfg.coef_xy),
                                           .p(t1));
  cpd_mulsh #(.FRAC_BITS(FRAC_BITS)) u_t2 (.clk, .en(1'b1), .a(p11), .b(cfg.coef_yy),
                                           .p(t2));
  cpd_mulsh #(.FRAC_BITS(FRAC_BITS)) u_t3 (.clk, .en(1'b1), .a(p22), .b(cfg.coef_xx),
                                           .p(t3));
  cpd_mulsh #(.FRAC_BITS(FRAC_BITS)) u_td (.clk, .en(1'b1), .a(det), .b(cfg.coef_const),
                                           .p(td));

  cpd_sqrt u_qsqrt (.clk, .en(1'b1), .rad(q2), .root(q));

  always_comb begin
    tol2      = 64'(cfg.tolerance) << FRAC_BITS;
    qs        = 34'(mag32(cfg.coef_xx)) + 34'(mag32(cfg.coef_xy)) + 34'(mag32(cfg.coef_yy));
    det_small = mag64(det) < tol2;
  end

  always_ff @(posedge clk) begin
    if (mag64(beta) >= tol2) begin
      if (det_small) cls <= CLS_PARABOLA;
      else cls <= (det >= signed'(tol2)) ? CLS_ELLIPSE : CLS_HYPERBOLA;
    end else if (det_small) begin
      if (qs >= 34'(cfg.tolerance)) cls <= CLS_TWO_LINES;
      else cls <= (ps < tol2) ? CLS_NONE : CLS_LINE;
    end else begin
      cls <= (det >= signed'(tol2)) ? CLS_NONE : CLS_TWO_LINES;
    end
  end

endmodule

`default_nettype wire

// File: sv/conic_point_distance.sv
// Conic point distance: throughput one point per cycle while the output buffer
// has room. The pipeline length is set by the two 32-stage square root
// pipelines and the 32-stage divider.
// Synchronous reset clears the pipeline and the output buffer and loads the
// configuration reset values; q and the class follow a write through cpd_conf.
`default_nettype none

module conic_point_distance #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpd_pkg::COEF_W-1:0]      cfg_data,
  cpd_in_if.sink                          points,
  cpd_out_if.source                       results
);
  import cpd_pkg::*;

  localparam int NUM_W = 33 + FRAC_BITS;

  cpd_cfg_t cfg;

  // Global pipeline advance; only the output buffer can hold it back
  logic adv;

  // front outputs
  logic               fr_v;
  logic signed [31:0] fr_f, fr_gx, fr_gy;
  logic [31:0]        fr_fm;
  logic [63:0]        fr_g2;

  // first root stage
  logic [31:0] g_root;
  logic        a_v;
  logic [191:0] a_data;

  // radicand stages
  logic               r1_v, r2_v;
  logic [63:0]        r1_p, r1_g2, r2_rad;
  logic [31:0]        r1_g, r1_fm, r2_g, r2_fm;
  logic signed [31:0] r1_f, r1_gx, r1_gy, r2_f, r2_gx, r2_gy;
  logic               r2_inv;
  logic [64:0]        rad_sum;

  // second root stage
  logic [31:0]  s_root;
  logic         b_v;
  logic [160:0] b_data;

  // divider input stage
  logic               d_v, d_inv, d_dz, d_gz;
  logic signed [31:0] d_f, d_gx, d_gy;
  logic [32:0]        d_den;
  logic [NUM_W-1:0]   d_num;

  // divider
  logic [DIST_W-1:0] quo;
  logic              ovf;
  logic              c_v;
  logic [98:0]       c_data;

  // final stage and output buffer
  logic              e_v;
  cpd_res_t          e_res;
  cpd_res_t          e_next;
  cpd_res_t          obuf [0:1];
  logic [1:0]        cnt;
  logic              wp, rp;
  logic              push, pop;
  conic_class_t      cls;
  logic [31:0]       q;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_const <= '0;
      cfg.coef_x     <= '0;
      cfg.coef_y     <= '0;
      cfg.coef_xx    <= '0;
      cfg.coef_xy    <= '0;
      cfg.coef_yy    <= '0;
      cfg.tolerance  <= TOL_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_COEF_CONST: cfg.coef_const <= cfg_data;
        REG_COEF_X:     cfg.coef_x     <= cfg_data;
        REG_COEF_Y:     cfg.coef_y     <= cfg_data;
        REG_COEF_XX:    cfg.coef_xx    <= cfg_data;
        REG_COEF_XY:    cfg.coef_xy    <= cfg_data;
        REG_COEF_YY:    cfg.coef_yy    <= cfg_data;
        REG_TOLERANCE:  cfg.tolerance  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // q and the class depend on configuration only and settle long before any
  // item reaches the stages that read them
  cpd_conf #(.FRAC_BITS(FRAC_BITS)) u_conf (.clk, .cfg, .q, .cls);

  assign adv          = !e_v || (cnt != 2'd2);
  assign points.ready = adv;

  cpd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en(adv), .cfg,
    .in_valid(points.valid && points.ready),
    .x(points.point_x), .y(points.point_y),
    .out_valid(fr_v), .f(fr_f), .gx(fr_gx), .gy(fr_gy), .fm(fr_fm), .g2(fr_g2)
  );

  // |g| = isqrt(|g|^2), side data travels alongside
  cpd_sqrt u_gsqrt (.clk, .en(adv), .rad(fr_g2), .root(g_root));
  cpd_delay #(.W(192), .DEPTH(SQRT_STEPS)) u_dly_a (
    .clk, .rst, .en(adv), .in_valid(fr_v),
    .in_data({fr_f, fr_gx, fr_gy, fr_fm, fr_g2}),
    .out_valid(a_v), .out_data(a_data)
  );

  // Radicand |g|^2 + 4 q |f|, saturated on overflow
  assign rad_sum = 65'(r1_g2) + 65'({r1_p[61:0], 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
    end else if (adv) begin
      r1_v <= a_v;
      r2_v <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_p  <= q * a_data[95:64];
      r1_g  <= g_root;
      r1_g2 <= a_data[63:0];
      r1_fm <= a_data[95:64];
      r1_f  <= a_data[191:160];
      r1_gx <= a_data[159:128];
      r1_gy <= a_data[127:96];
      if (r1_p[63:62] != 2'b00 || rad_sum[64]) begin
        r2_rad <= '1;
        r2_inv <= 1'b1;
      end else begin
        r2_rad <= rad_sum[63:0];
        r2_inv <= 1'b0;
      end
      r2_g  <= r1_g;
      r2_fm <= r1_fm;
      r2_f  <= r1_f;
      r2_gx <= r1_gx;
      r2_gy <= r1_gy;
    end
  end

  cpd_sqrt u_rsqrt (.clk, .en(adv), .rad(r2_rad), .root(s_root));
  cpd_delay #(.W(161), .DEPTH(SQRT_STEPS)) u_dly_b (
    .clk, .rst, .en(adv), .in_valid(r2_v),
    .in_data({r2_f, r2_gx, r2_gy, r2_fm, r2_g, r2_inv}),
    .out_valid(b_v), .out_data(b_data)
  );

  // Stable form: 2|f| / (|g| + sqrt(rad))
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_den <= 33'(b_data[32:1]) + 33'(s_root);
      d_num <= NUM_W'(b_data[64:33]) << (FRAC_BITS + 1);
      d_dz  <= (b_data[32:1] == 32'd0) && (s_root == 32'd0);
      d_gz  <= b_data[32:1] == 32'd0;
      d_inv <= b_data[0];
      d_f   <= b_data[160:129];
      d_gx  <= b_data[128:97];
      d_gy  <= b_data[96:65];
    end
  end

  cpd_div #(.NUM_W(NUM_W)) u_div (.clk, .en(adv), .num(d_num), .den(d_den), .quo, .ovf);
  cpd_delay #(.W(99), .DEPTH(DIV_STEPS + 1)) u_dly_c (
    .clk, .rst, .en(adv), .in_valid(d_v),
    .in_data({d_f, d_gx, d_gy, d_inv, d_dz, d_gz}),
    .out_valid(c_v), .out_data(c_data)
  );

  // Pick the distance: both norms zero, critical point, overflow, or quotient
  always_comb begin
    e_next.conic_value = c_data[98:67];
    e_next.grad_x      = c_data[66:35];
    e_next.grad_y      = c_data[34:3];
    e_next.conic_class = cls;
    if (q == 32'd0 && c_data[0]) begin
      e_next.approx_distance  = DMAX;
      e_next.distance_invalid = 1'b1;
    end else if (c_data[1]) begin
      e_next.approx_distance  = '0;
      e_next.distance_invalid = c_data[2];
    end else if (ovf) begin
      e_next.approx_distance  = DMAX;
      e_next.distance_invalid = 1'b1;
    end else begin
      e_next.approx_distance  = quo;
      e_next.distance_invalid = c_data[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_res <= e_next;
    end
  end

  // Two-entry output buffer keeps the pipeline moving while a result waits
  assign push = adv && e_v;
  assign pop  = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wp] <= e_res;
    end
  end

  assign results.valid            = cnt != 2'd0;
  assign results.conic_value      = obuf[rp].conic_value;
  assign results.grad_x           = obuf[rp].grad_x;
  assign results.grad_y           = obuf[rp].grad_y;
  assign results.approx_distance  = obuf[rp].approx_distance;
  assign results.distance_invalid = obuf[rp].distance_invalid;
  assign results.conic_class      = obuf[rp].conic_class;

endmodule

`default_nettype wire
